>>> rtl/ttf_pkg.sv
package ttf_pkg;

  localparam int PosWidth = 32;
  localparam int UvWidth  = 16;
  localparam int OutWidth = 16;

  localparam int EdgeDrop = (PosWidth > 32) ? PosWidth - 32 : 0;
  localparam int UvDrop   = (UvWidth > 16) ? UvWidth - 16 : 0;
  localparam int EdgeW    = 33;
  localparam int DeltaW   = 17;
  localparam int ProdW    = 2 * EdgeW;
  localparam int ResW     = 52;
  localparam int NormTop  = 29;
  localparam int FracBits = OutWidth - 2;
  localparam int QuoW     = OutWidth - 1;
  localparam int NumW     = 32 + FracBits;
  localparam int RemW     = 32;
  localparam int SqW      = 64;

  typedef struct packed {
    logic signed [PosWidth-1:0] pos_x;
    logic signed [PosWidth-1:0] pos_y;
    logic signed [PosWidth-1:0] pos_z;
    logic signed [UvWidth-1:0]  tex_u;
    logic signed [UvWidth-1:0]  tex_v;
  } ttf_in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] tangent_x;
    logic signed [OutWidth-1:0] tangent_y;
    logic signed [OutWidth-1:0] tangent_z;
    logic signed [OutWidth-1:0] bitangent_x;
    logic signed [OutWidth-1:0] bitangent_y;
    logic signed [OutWidth-1:0] bitangent_z;
    logic                       degenerate;
  } ttf_out_t;

  typedef struct packed {
    logic [2:0][EdgeW-1:0] e1;
    logic [2:0][EdgeW-1:0] e2;
    logic [DeltaW-1:0]     d1u;
    logic [DeltaW-1:0]     d1v;
    logic [DeltaW-1:0]     d2u;
    logic [DeltaW-1:0]     d2v;
  } ttf_job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ttf_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_LOAD,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIVINIT,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } ttf_state_e;

  function automatic logic [EdgeW-1:0] edge_f(logic [PosWidth-1:0] a, logic [PosWidth-1:0] b);
    logic signed [PosWidth:0] d;
    logic signed [PosWidth:0] s;
    d = $signed({a[PosWidth-1], a}) - $signed({b[PosWidth-1], b});
    s = d >>> EdgeDrop;
    return EdgeW'(s);
  endfunction

  function automatic logic [DeltaW-1:0] delta_f(logic [UvWidth-1:0] a, logic [UvWidth-1:0] b);
    logic signed [UvWidth:0] d;
    logic signed [UvWidth:0] s;
    d = $signed({a[UvWidth-1], a}) - $signed({b[UvWidth-1], b});
    s = d >>> UvDrop;
    return DeltaW'(s);
  endfunction

endpackage

>>> rtl/ttf_mul.sv
module ttf_mul (
  input  logic                               clk_i,
  input  logic signed [ttf_pkg::EdgeW-1:0]   a_i,
  input  logic signed [ttf_pkg::EdgeW-1:0]   b_i,
  output logic signed [ttf_pkg::ProdW-1:0]   p_o
);
  import ttf_pkg::*;

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> rtl/ttf_core.sv
module ttf_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ttf_pkg::ttf_job_t     job_i,
  input  logic                  out_free_i,
  output ttf_pkg::ttf_status_t  status_o,
  output ttf_pkg::ttf_out_t     result_o
);
  import ttf_pkg::*;

  ttf_state_e state_q, state_d;
  ttf_job_t job_q, job_d;
  logic [3:0] k_q, k_d;
  logic signed [ProdW-1:0] acc_q, acc_d;
  logic [6:0][ResW-1:0] res_q, res_d;
  logic det_neg_q, det_neg_d;
  logic vec_q, vec_d;
  logic [1:0] comp_q, comp_d;
  logic [2:0][ResW-1:0] mag_q, mag_d;
  logic [2:0] sgn_q, sgn_d;
  logic [SqW-1:0] s_q, s_d;
  logic [SqW-1:0] r_q, r_d;
  logic [4:0] it_q, it_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [QuoW-1:0] lo_q, lo_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [5:0][OutWidth-1:0] outv_q, outv_d;
  logic degen_q, degen_d;

  logic signed [EdgeW-1:0] ma, mb;
  logic signed [ProdW-1:0] prod;

  ttf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    k_q       <= k_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    det_neg_q <= det_neg_d;
    vec_q     <= vec_d;
    comp_q    <= comp_d;
    mag_q     <= mag_d;
    sgn_q     <= sgn_d;
    s_q       <= s_d;
    r_q       <= r_d;
    it_q      <= it_d;
    rem_q     <= rem_d;
    lo_q      <= lo_d;
    quo_q     <= quo_d;
    outv_q    <= outv_d;
    degen_q   <= degen_d;
  end

  always_comb begin
    logic [2:0] j;
    logic [2:0] jj;
    logic [1:0] ci;
    logic signed [ProdW-1:0] diff;
    logic signed [ResW-1:0] v;
    logic [ResW-1:0] ormag;
    logic [SqW-1:0] bitv;
    logic [SqW-1:0] trial;
    logic [NumW-1:0] num;
    logic [RemW:0] t;
    logic [RemW-1:0] len;
    logic [QuoW-1:0] q;
    logic [OutWidth-1:0] qo;
    logic [2:0] slot;

    state_d = state_q;
    job_d = job_q;
    k_d = k_q;
    acc_d = acc_q;
    res_d = res_q;
    det_neg_d = det_neg_q;
    vec_d = vec_q;
    comp_d = comp_q;
    mag_d = mag_q;
    sgn_d = sgn_q;
    s_d = s_q;
    r_d = r_q;
    it_d = it_q;
    rem_d = rem_q;
    lo_d = lo_q;
    quo_d = quo_q;
    outv_d = outv_q;
    degen_d = degen_q;
    ma = '0;
    mb = '0;
    j = 3'(k_q >> 1);
    jj = 3'((k_q - 4'd1) >> 1);
    ci = 2'd0;
    diff = '0;
    v = '0;
    ormag = mag_q[0] | mag_q[1] | mag_q[2];
    bitv = SqW'(1) << {it_q, 1'b0};
    trial = r_q + bitv;
    len = r_q[RemW-1:0];
    num = '0;
    t = {rem_q, lo_q[QuoW-1]};
    q = '0;
    qo = '0;
    slot = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          job_d = job_i;
          k_d = '0;
          degen_d = 1'b0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (k_q < 4'd14) begin
          if (j == 3'd0) begin
            ma = EdgeW'($signed(k_q[0] ? job_q.d1u : job_q.d1v));
            mb = EdgeW'($signed(k_q[0] ? job_q.d2v : job_q.d2u));
          end else if (j < 3'd4) begin
            ci = 2'(j - 3'd1);
            ma = $signed(k_q[0] ? job_q.e1[ci] : job_q.e2[ci]);
            mb = EdgeW'($signed(k_q[0] ? job_q.d2v : job_q.d1v));
          end else begin
            ci = 2'(j - 3'd4);
            ma = $signed(k_q[0] ? job_q.e1[ci] : job_q.e2[ci]);
            mb = EdgeW'($signed(k_q[0] ? job_q.d2u : job_q.d1u));
          end
        end
        if (k_q != 4'd0) begin
          if (!k_q[0]) begin
            diff = acc_q - prod;
            if (jj == 3'd0) begin
              res_d[0] = ResW'(diff);
              det_neg_d = diff < 0;
            end else begin
              res_d[jj] = ResW'(det_neg_q ? -diff : diff);
            end
          end else begin
            acc_d = prod;
          end
        end
        k_d = k_q + 4'd1;
        if (k_q == 4'd14) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        vec_d = 1'b0;
        if (res_q[0] == '0) begin
          degen_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          v = $signed(res_q[3'(1 + 3 * int'(vec_q) + i)]);
          sgn_d[i] = v < 0;
          mag_d[i] = (v < 0) ? ResW'(-v) : ResW'(v);
        end
        state_d = ST_NORM;
      end
      ST_NORM: begin
        if (ormag == '0) begin
          degen_d = 1'b1;
          state_d = ST_DONE;
        end else if (|ormag[ResW-1:NormTop+1]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!ormag[NormTop]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          k_d = '0;
          s_d = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (k_q < 4'd3) begin
          ma = $signed(EdgeW'(mag_q[k_q[1:0]][NormTop:0]));
          mb = ma;
        end
        if (k_q != 4'd0) begin
          s_d = s_q + SqW'(prod);
        end
        k_d = k_q + 4'd1;
        if (k_q == 4'd3) begin
          r_d = '0;
          it_d = 5'd31;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (s_q >= trial) begin
          s_d = s_q - trial;
          r_d = (r_q >> 1) + bitv;
        end else begin
          r_d = r_q >> 1;
        end
        it_d = it_q - 5'd1;
        if (it_q == 5'd0) begin
          comp_d = 2'd0;
          state_d = ST_DIVINIT;
        end
      end
      ST_DIVINIT: begin
        num = (NumW'(mag_q[comp_q][NormTop:0]) << FracBits) + NumW'(len >> 1);
        rem_d = RemW'(num >> QuoW);
        lo_d = num[QuoW-1:0];
        quo_d = '0;
        it_d = 5'(QuoW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (t >= {1'b0, len}) begin
          rem_d = RemW'(t - {1'b0, len});
          quo_d = {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_d = RemW'(t);
          quo_d = {quo_q[QuoW-2:0], 1'b0};
        end
        lo_d = lo_q << 1;
        it_d = it_q - 5'd1;
        if (it_q == 5'd0) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        q = (quo_q > (QuoW'(1) << FracBits)) ? (QuoW'(1) << FracBits) : quo_q;
        qo = OutWidth'(q);
        slot = 3'(3 * int'(vec_q) + int'(comp_q));
        outv_d[slot] = sgn_q[comp_q] ? -qo : qo;
        if (comp_q == 2'd2) begin
          if (!vec_q) begin
            vec_d = 1'b1;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          comp_d = comp_q + 2'd1;
          state_d = ST_DIVINIT;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign status_o.busy = (state_q != ST_IDLE);
  assign status_o.done = (state_q == ST_DONE) && out_free_i;

  assign result_o.tangent_x   = degen_q ? '0 : outv_q[0];
  assign result_o.tangent_y   = degen_q ? '0 : outv_q[1];
  assign result_o.tangent_z   = degen_q ? '0 : outv_q[2];
  assign result_o.bitangent_x = degen_q ? '0 : outv_q[3];
  assign result_o.bitangent_y = degen_q ? '0 : outv_q[4];
  assign result_o.bitangent_z = degen_q ? '0 : outv_q[5];
  assign result_o.degenerate  = degen_q;

endmodule

>>> rtl/triangle_tangent_frame.sv
// Takes triangle corners one transfer at a time and, on every third corner, returns the
// unit tangent and unit bitangent of the triangle in signed Q2.14 with a degenerate flag.
// The first two corners of a triangle are taken in one cycle each. The third corner
// occupies the shared multiplier and the bit-serial square root and divider; when a frame
// is formed it passes through the multiplies, the one-bit normalizing shifts (0 to 29 per
// vector), the 32-step square roots and the six 15-step divisions, and a zero uv
// determinant ends the work after the multiplies. The core then waits while the previous
// result is still stalled. No corner is taken during that time.
module triangle_tangent_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ttf_pkg::ttf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ttf_pkg::ttf_out_t out_data_o
);
  import ttf_pkg::*;

  logic [1:0] count_q, count_d;
  logic [1:0][2:0][PosWidth-1:0] pos_q;
  logic [1:0][1:0][UvWidth-1:0] uv_q;
  logic out_valid_q, out_valid_d;
  ttf_out_t out_data_q;
  ttf_out_t core_result;
  ttf_status_t status;
  ttf_job_t job;
  logic in_xfer, start, out_free;

  assign in_stall_o = status.busy;
  assign in_xfer = in_valid_i && !status.busy;
  assign start = in_xfer && (count_q == 2'd2);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    job.e1[0] = edge_f(pos_q[1][0], pos_q[0][0]);
    job.e1[1] = edge_f(pos_q[1][1], pos_q[0][1]);
    job.e1[2] = edge_f(pos_q[1][2], pos_q[0][2]);
    job.e2[0] = edge_f(in_data_i.pos_x, pos_q[0][0]);
    job.e2[1] = edge_f(in_data_i.pos_y, pos_q[0][1]);
    job.e2[2] = edge_f(in_data_i.pos_z, pos_q[0][2]);
    job.d1u = delta_f(uv_q[1][0], uv_q[0][0]);
    job.d1v = delta_f(uv_q[1][1], uv_q[0][1]);
    job.d2u = delta_f(in_data_i.tex_u, uv_q[0][0]);
    job.d2v = delta_f(in_data_i.tex_v, uv_q[0][1]);
  end

  always_comb begin
    count_d = count_q;
    if (in_xfer) begin
      count_d = (count_q == 2'd2) ? 2'd0 : count_q + 2'd1;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (status.done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && count_q != 2'd2) begin
      pos_q[count_q[0]] <= {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
      uv_q[count_q[0]]  <= {in_data_i.tex_v, in_data_i.tex_u};
    end
    if (status.done) begin
      out_data_q <= core_result;
    end
  end

  ttf_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .job_i      (job),
    .out_free_i (out_free),
    .status_o   (status),
    .result_o   (core_result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_done_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> (!out_valid_q || !out_stall_i))
    else $error("result finished while output slot occupied");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("corner count out of range");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.tangent_x == '0 && out_data_o.tangent_y == '0 &&
       out_data_o.tangent_z == '0 && out_data_o.bitangent_x == '0 &&
       out_data_o.bitangent_y == '0 && out_data_o.bitangent_z == '0))
    else $error("degenerate result with nonzero vector");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> status.busy)
    else $error("core did not start on third corner");

endmodule

>>> bench/triangle_tangent_frame_test.sv
`timescale 1ns / 100ps

module triangle_tangent_frame_test;
  import ttf_pkg::*;

  localparam int StallLimit = 20000;
  localparam int RandomItems = 549;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ttf_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ttf_out_t out_data;

  triangle_tangent_frame dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  typedef struct {
    ttf_in_t  corner;
    logic     fixed;
    ttf_out_t frame;
  } corner_row_t;

  ttf_out_t frame_queue[$];
  longint   held_pos[6];
  longint   held_uv[4];
  int       corner_idx;
  int       errors;
  int       idle_cycles;
  bit       sending_done;

  function automatic longint isqrt_u(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit normalize(input longint v[3], output logic [OutWidth-1:0] o[3]);
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned s;
    longint unsigned len;
    longint unsigned q;
    int top;
    mx = 0;
    s = 0;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 1'b0;
    while ((mx >> top) > 1) top++;
    for (int i = 0; i < 3; i++) begin
      if (top > NormTop) mag[i] >>= (top - NormTop);
      else mag[i] <<= (NormTop - top);
      s += mag[i] * mag[i];
    end
    len = isqrt_u(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FracBits) + (len >> 1)) / len;
      if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
      o[i] = (v[i] < 0) ? OutWidth'(-q) : OutWidth'(q);
    end
    return 1'b1;
  endfunction

  function automatic bit frame_of_corner(input ttf_in_t c, output ttf_out_t r);
    longint p[3];
    longint e1[3];
    longint e2[3];
    longint t[3];
    longint b[3];
    longint d1u, d1v, d2u, d2v, det;
    logic [OutWidth-1:0] tu[3];
    logic [OutWidth-1:0] bu[3];
    p[0] = c.pos_x;
    p[1] = c.pos_y;
    p[2] = c.pos_z;
    if (corner_idx < 2) begin
      for (int i = 0; i < 3; i++) held_pos[corner_idx*3+i] = p[i];
      held_uv[corner_idx*2] = c.tex_u;
      held_uv[corner_idx*2+1] = c.tex_v;
      corner_idx++;
      return 1'b0;
    end
    corner_idx = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = (held_pos[3+i] - held_pos[i]) >>> EdgeDrop;
      e2[i] = (p[i] - held_pos[i]) >>> EdgeDrop;
    end
    d1u = held_uv[2] - held_uv[0];
    d1v = held_uv[3] - held_uv[1];
    d2u = longint'(c.tex_u) - held_uv[0];
    d2v = longint'(c.tex_v) - held_uv[1];
    det = d1v * d2u - d1u * d2v;
    for (int i = 0; i < 3; i++) begin
      t[i] = e2[i] * d1v - e1[i] * d2v;
      b[i] = e2[i] * d1u - e1[i] * d2u;
      if (det < 0) begin
        t[i] = -t[i];
        b[i] = -b[i];
      end
    end
    r = '0;
    if (det == 0 || !normalize(t, tu) || !normalize(b, bu)) begin
      r.degenerate = 1'b1;
    end else begin
      r.tangent_x = tu[0];
      r.tangent_y = tu[1];
      r.tangent_z = tu[2];
      r.bitangent_x = bu[0];
      r.bitangent_y = bu[1];
      r.bitangent_z = bu[2];
    end
    return 1'b1;
  endfunction

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ttf_in_t make_corner(ttf_in_t anchor, int shape);
    ttf_in_t c;
    c.pos_x = $urandom;
    c.pos_y = $urandom;
    c.pos_z = $urandom;
    c.tex_u = $urandom;
    c.tex_v = $urandom;
    if (shape < 70) begin
      c.pos_x = anchor.pos_x + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      c.pos_y = anchor.pos_y + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      c.pos_z = anchor.pos_z + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      c.tex_u = anchor.tex_u + $signed($urandom_range(0, 8192)) - 4096;
      c.tex_v = anchor.tex_v + $signed($urandom_range(0, 8192)) - 4096;
    end else if (shape < 78) begin
      c.tex_u = anchor.tex_u;
    end else if (shape < 84) begin
      c = anchor;
    end
    return c;
  endfunction

  task automatic send_corner(ttf_in_t c);
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    repeat (gap_length()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic accept_corner(ttf_in_t c);
    ttf_out_t r;
    if (frame_of_corner(c, r)) frame_queue.insert(frame_queue.size(), r);
  endtask

  corner_row_t rows[$];

  initial begin
    corner_row_t row;
    ttf_in_t anchor;
    ttf_in_t c;
    int shape;
    errors = 0;
    corner_idx = 0;
    sending_done = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    row.fixed = 1'b0;
    row.frame = '0;
    row.corner = '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0};
    rows.insert(rows.size(), row);
    row.corner = '{32'sd65536, 32'sd0, 32'sd0, 16'sd4096, 16'sd0};
    rows.insert(rows.size(), row);
    row.corner = '{32'sd0, 32'sd65536, 32'sd0, 16'sd0, 16'sd4096};
    row.fixed = 1'b1;
    row.frame = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 1'b0};
    rows.insert(rows.size(), row);
    row.fixed = 1'b0;
    row.corner = '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0};
    rows.insert(rows.size(), row);
    row.corner = '{32'sd65536, 32'sd0, 32'sd0, 16'sd4096, 16'sd4096};
    rows.insert(rows.size(), row);
    row.corner = '{32'sd0, 32'sd65536, 32'sd0, 16'sd8192, 16'sd8192};
    row.fixed = 1'b1;
    row.frame = '0;
    row.frame.degenerate = 1'b1;
    rows.insert(rows.size(), row);
    row.fixed = 1'b0;
    row.corner = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h7fff, 16'h8000};
    rows.insert(rows.size(), row);
    row.corner = '{32'h80000000, 32'h7fffffff, 32'h80000000, 16'h8000, 16'h7fff};
    rows.insert(rows.size(), row);
    row.corner = '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'h8000, 16'h8000};
    rows.insert(rows.size(), row);
    row.corner = '{32'h12345678, 32'h0, 32'h0, 16'h0, 16'h0};
    rows.insert(rows.size(), row);
    row.corner = '{32'h12345678, 32'h0, 32'h0, 16'h1000, 16'h0};
    rows.insert(rows.size(), row);
    row.corner = '{32'h12345678, 32'h0, 32'h0, 16'h0, 16'h1000};
    rows.insert(rows.size(), row);
    row.corner = '{-32'sd1, -32'sd1, -32'sd1, -16'sd1, -16'sd1};
    rows.insert(rows.size(), row);
    row.corner = '{32'sd1, 32'sd0, 32'sd0, 16'sd1, 16'sd0};
    rows.insert(rows.size(), row);
    row.corner = '{32'sd0, 32'sd1, 32'sd1, 16'sd0, 16'sd1};
    rows.insert(rows.size(), row);

    foreach (rows[i]) begin
      accept_corner(rows[i].corner);
      if (rows[i].fixed) begin
        frame_queue[frame_queue.size() - 1] = rows[i].frame;
      end
      send_corner(rows[i].corner);
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        while (frame_queue.size() != 0) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
      end
      if (corner_idx == 0) begin
        anchor.pos_x = $urandom;
        anchor.pos_y = $urandom;
        anchor.pos_z = $urandom;
        anchor.tex_u = $urandom;
        anchor.tex_v = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          anchor.pos_x = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
          anchor.pos_y = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
          anchor.pos_z = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        end
        c = anchor;
      end else begin
        shape = $urandom_range(0, 99);
        c = make_corner(anchor, shape);
      end
      accept_corner(c);
      send_corner(c);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        repeat (1 + gap_length()) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    ttf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data);
        errors++;
      end else begin
        want = frame_queue.pop_front();
        if (out_data.tangent_x !== want.tangent_x)
          $display("%0t: tangent_x expected %0d actual %0d", $realtime, want.tangent_x,
                   out_data.tangent_x);
        if (out_data.tangent_y !== want.tangent_y)
          $display("%0t: tangent_y expected %0d actual %0d", $realtime, want.tangent_y,
                   out_data.tangent_y);
        if (out_data.tangent_z !== want.tangent_z)
          $display("%0t: tangent_z expected %0d actual %0d", $realtime, want.tangent_z,
                   out_data.tangent_z);
        if (out_data.bitangent_x !== want.bitangent_x)
          $display("%0t: bitangent_x expected %0d actual %0d", $realtime, want.bitangent_x,
                   out_data.bitangent_x);
        if (out_data.bitangent_y !== want.bitangent_y)
          $display("%0t: bitangent_y expected %0d actual %0d", $realtime, want.bitangent_y,
                   out_data.bitangent_y);
        if (out_data.bitangent_z !== want.bitangent_z)
          $display("%0t: bitangent_z expected %0d actual %0d", $realtime, want.bitangent_z,
                   out_data.bitangent_z);
        if (out_data.degenerate !== want.degenerate)
          $display("%0t: degenerate expected %0d actual %0d", $realtime, want.degenerate,
                   out_data.degenerate);
        if (out_data !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
      if (sending_done && frame_queue.size() == 0) begin
        repeat (300) @(posedge clk);
        if (errors == 0 && frame_queue.size() == 0) begin
          $display("Test completed successfully");
        end else begin
          $display("Test completed with failures");
        end
        $finish;
      end
    end
  end

endmodule
